### rtl/bsst_pkg.sv
// ----------------------------------------------------------------------------
// bsst_pkg
// Shared types and constants of the bounded set span tracker.
// ----------------------------------------------------------------------------
package bsst_pkg;

   localparam int VALUE_W     = 32;
   localparam int CAP_W       = 11;
   localparam int COUNT_OUT_W = 11;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [VALUE_W-1:0] SPAN_NONE = {VALUE_W{1'b1}};

   // register index decoded from paddr[2]
   localparam logic REG_CAPACITY = 1'b0;

   // status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_REPORT
   } state_type;

endpackage

### rtl/bsst_ram.sv
// ----------------------------------------------------------------------------
// bsst_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module bsst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bsst_csr.sv
// ----------------------------------------------------------------------------
// bsst_csr
// APB-style register file holding the capacity register.
// ----------------------------------------------------------------------------
module bsst_csr
   import bsst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [CAP_W-1:0]      capacity
);

   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] capacity_in;
   logic             wr_cap;

   assign pready = 1'b1;
   assign wr_cap = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

   always_comb begin
      capacity_in = capacity_ff;
      if (wr_cap) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_CAPACITY) begin
         prdata = CSR_DATA_W'(capacity_ff);
      end
   end

   assign capacity = capacity_ff;

endmodule

### rtl/bounded_set_span_tracker.sv
// ----------------------------------------------------------------------------
// bounded_set_span_tracker
// Bounded multiset of signed numbers reporting shortest and longest span.
// ----------------------------------------------------------------------------
// Command channel: a transfer is taken when start is high and busy is low;
// req_value is the number to add. Each add gives one result, shown on the
// rsp_ ports for a single cycle while rsp_strobe is high; the receiver
// cannot stall, so results are never held back.
// An add is rejected with rsp_status high when the store already holds
// capacity values (capacity 0 is always full, capacity saturates at
// STORE_DEPTH); the result then appears in the next cycle and busy stays low.
// An accepted add with n values held reads the store once per held value
// through the single read port of the value memory. With n of one or more,
// busy stays high through the n reads, the drain of the read and compare
// pipeline, the write state and the report state. The first value skips the
// scan and drain and keeps busy high for the write and report states only.
// The result appears in the first cycle with busy low, and the next transfer
// can be taken in that same cycle. capacity is written through the APB-style
// port; the user must do so only while the block is idle (not enforced).
// Synchronous reset empties the store (the count goes to zero, the memory
// is not cleared), sets capacity to 0 and drops any add in flight.
// ----------------------------------------------------------------------------
module bounded_set_span_tracker
   import bsst_pkg::*;
#(
   parameter int STORE_DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_strobe,
   output logic                      rsp_status,
   output logic [COUNT_OUT_W-1:0]    rsp_held_count,
   output logic                      rsp_span_valid,
   output logic [VALUE_W-1:0]        rsp_shortest_span,
   output logic [VALUE_W-1:0]        rsp_longest_span,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]     prdata,
   output logic                      pready
);

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   state_type state_ff, state_in;

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic signed [VALUE_W-1:0] min_ff, min_in;
   logic signed [VALUE_W-1:0] max_ff, max_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [VALUE_W-1:0]        min_gap_ff, min_gap_in;
   logic [ADDR_W-1:0]         rd_addr_ff, rd_addr_in;
   logic                      rd_pend_ff, rd_pend_in;
   logic [VALUE_W-1:0]        gap_ff, gap_in;
   logic                      gap_vld_ff, gap_vld_in;

   logic                      rsp_strobe_ff;
   logic                      rsp_status_ff;
   logic [COUNT_OUT_W-1:0]    rsp_held_count_ff;
   logic                      rsp_span_valid_ff;
   logic [VALUE_W-1:0]        rsp_shortest_span_ff;
   logic [VALUE_W-1:0]        rsp_longest_span_ff;

   logic                      rsp_load;
   logic                      rsp_status_in;
   logic                      span_valid;
   logic [VALUE_W:0]          range_diff;
   logic [VALUE_W:0]          diff;
   logic [VALUE_W:0]          diff_abs;

   logic [CAP_W-1:0]          capacity;
   logic [CMP_W-1:0]          cap_eff;
   logic                      full;

   logic                      mem_re;
   logic                      mem_we;
   logic [VALUE_W-1:0]        mem_rdata;

   bsst_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   bsst_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (value_ff),
      .rd_en   (mem_re),
      .rd_addr (rd_addr_ff),
      .rd_data (mem_rdata)
   );

   // effective capacity and full check
   always_comb begin
      if (CMP_W'(capacity) > CMP_W'(STORE_DEPTH)) begin
         cap_eff = CMP_W'(STORE_DEPTH);
      end else begin
         cap_eff = CMP_W'(capacity);
      end
      full = CMP_W'(count_ff) >= cap_eff;
   end

   // exact 33-bit distance between the new value and a stored one
   always_comb begin
      diff       = {value_ff[VALUE_W-1], value_ff} - {mem_rdata[VALUE_W-1], mem_rdata};
      diff_abs   = diff[VALUE_W] ? (~diff + 1'b1) : diff;
      gap_in     = diff_abs[VALUE_W-1:0];
      gap_vld_in = rd_pend_ff;
   end

   // result fields from the current state
   always_comb begin
      span_valid = count_ff >= CNT_W'(2);
      range_diff = {max_ff[VALUE_W-1], max_ff} - {min_ff[VALUE_W-1], min_ff};
   end

   always_comb begin
      state_in      = state_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      min_gap_in    = min_gap_ff;
      rd_addr_in    = rd_addr_ff;
      rd_pend_in    = 1'b0;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      rsp_load      = 1'b0;
      rsp_status_in = STATUS_OK;

      if (gap_vld_ff && (gap_ff < min_gap_ff)) begin
         min_gap_in = gap_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in = req_value;
               if (full) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = STATUS_FULL;
               end else if (count_ff == '0) begin
                  state_in = ST_WRITE;
               end else begin
                  rd_addr_in = '0;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            mem_re     = 1'b1;
            rd_pend_in = 1'b1;
            rd_addr_in = rd_addr_ff + ADDR_W'(1);
            if ((CNT_W'(rd_addr_ff) + CNT_W'(1)) == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_pend_ff && !gap_vld_ff) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            mem_we   = 1'b1;
            count_in = count_ff + CNT_W'(1);
            if (count_ff == '0) begin
               min_in = value_ff;
               max_in = value_ff;
            end else begin
               if (value_ff < min_ff) begin
                  min_in = value_ff;
               end
               if (value_ff > max_ff) begin
                  max_in = value_ff;
               end
            end
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            rsp_load = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         min_gap_ff    <= SPAN_NONE;
         rd_pend_ff    <= 1'b0;
         gap_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         min_gap_ff    <= min_gap_in;
         rd_pend_ff    <= rd_pend_in;
         gap_vld_ff    <= gap_vld_in;
         rsp_strobe_ff <= rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      min_ff     <= min_in;
      max_ff     <= max_in;
      rd_addr_ff <= rd_addr_in;
      gap_ff     <= gap_in;
      if (rsp_load) begin
         rsp_status_ff        <= rsp_status_in;
         rsp_held_count_ff    <= COUNT_OUT_W'(count_ff);
         rsp_span_valid_ff    <= span_valid;
         rsp_shortest_span_ff <= span_valid ? min_gap_ff : SPAN_NONE;
         rsp_longest_span_ff  <= span_valid ? range_diff[VALUE_W-1:0] : '0;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_held_count    = rsp_held_count_ff;
   assign rsp_span_valid    = rsp_span_valid_ff;
   assign rsp_shortest_span = rsp_shortest_span_ff;
   assign rsp_longest_span  = rsp_longest_span_ff;

endmodule

### rtl/bsst_checker.sv
// ----------------------------------------------------------------------------
// bsst_checker
// Port-level checks of the span tracker, bound to the top level.
// ----------------------------------------------------------------------------
module bsst_checker
   import bsst_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_strobe,
   input logic                      rsp_status,
   input logic                      rsp_span_valid,
   input logic [VALUE_W-1:0]        rsp_shortest_span,
   input logic [VALUE_W-1:0]        rsp_longest_span
);

   // a transfer either goes busy or is answered as rejected right away
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || (rsp_strobe && rsp_status == STATUS_FULL))
      else $error("accepted transfer neither busy nor rejected");

   // end of a busy phase delivers an accepted result
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe && rsp_status == STATUS_OK)
      else $error("busy fell without an accepted result");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_span_valid |-> rsp_longest_span >= rsp_shortest_span)
      else $error("shortest span exceeds longest span");

   a_no_span: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_span_valid |->
         rsp_shortest_span == SPAN_NONE && rsp_longest_span == '0)
      else $error("invalid span not reported as empty");

endmodule

bind bounded_set_span_tracker bsst_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_status        (rsp_status),
   .rsp_span_valid    (rsp_span_valid),
   .rsp_shortest_span (rsp_shortest_span),
   .rsp_longest_span  (rsp_longest_span)
);
